>>> hdl/jsb_pkg.sv
// Shared types and constants of the JTAG scan command builder.
`default_nettype none
package jsb_pkg;

	localparam int MAX_SHIFT_BITS_DEF = 64;
	localparam int PROLOG_MAX         = 14;
	localparam int CHUNK_BITS         = 7;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [7:0] OP_TMS_WRITE = 8'h4b;
	localparam logic [7:0] OP_TMS_READ  = 8'h6b;
	localparam logic [7:0] OP_BYTES_RW  = 8'h39;
	localparam logic [7:0] OP_BYTES_W   = 8'h19;
	localparam logic [7:0] OP_BITS_RW   = 8'h3b;
	localparam logic [7:0] OP_BITS_W    = 8'h1b;
	localparam logic [7:0] FINAL_BIT_BASE = 8'h03;

	// Classified request, without the data word, which travels beside it.
	typedef struct packed {
		logic [3:0]  pbits;
		logic [13:0] ppat;
		logic [3:0]  nbytes;
		logic [2:0]  nrest;
		logic        fbit_en;
		logic        fbit;
		logic        rd;
		logic [2:0]  ebits;
		logic [6:0]  epat;
		logic [3:0]  reply;
	} jsb_desc_t;

endpackage
`default_nettype wire

>>> hdl/jtag_scan_command_builder.sv
// Top level of the JTAG scan command builder.
// A scan request is one transaction on the command port: it is taken at a
// rising edge with start high and busy low, all request fields sampled there.
// The front end clamps and classifies the request into a descriptor and puts
// it in a two-entry queue; busy is high only while that queue is full.
// The byte sequencer pops a descriptor and emits its command stream one byte
// per cycle: strobe marks each byte for exactly one cycle, is_last marks the
// final byte of the request, and reply_count holds the reply byte count of
// the request on every byte. A request of N bytes (at most 25) occupies the
// sequencer for its N bytes plus the idle step in which it pops the descriptor;
// a taken request passes through the queue, the sequencer state and the output
// register before its first byte appears. The sequencer sets the sustained rate.
// A request with no prolog, no data and no epilog is accepted and emits no
// bytes. The receiver has no way to stall; every strobed byte is taken.
// Reset empties the queue and returns the sequencer to idle; no byte is
// strobed until a request is accepted afterwards.
`default_nettype none
module jtag_scan_command_builder #(
	parameter int MAX_SHIFT_BITS = jsb_pkg::MAX_SHIFT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  prolog_bits,
	input  wire logic [13:0] prolog_pattern,
	input  wire logic [6:0]  shift_bits,
	input  wire logic [63:0] shift_data,
	input  wire logic        capture,
	input  wire logic [2:0]  epilog_bits,
	input  wire logic [6:0]  epilog_pattern,
	output logic             strobe,
	output logic [7:0]       cmd_byte,
	output logic             is_last,
	output logic [3:0]       reply_count
);
	import jsb_pkg::*;

	// Data bits that can reach a byte: whole bytes covering the longest shift.
	localparam int DW = ((MAX_SHIFT_BITS + 7) / 8) * 8;
	localparam int QW = $bits(jsb_desc_t) + DW;

	jsb_desc_t     push_desc;
	logic [DW-1:0] push_data;
	logic          push;
	jsb_desc_t     head_desc;
	logic [DW-1:0] head_data;
	logic          pop;
	logic          queue_full;
	logic          queue_empty;

	jsb_front #(
		.MAX_SHIFT_BITS(MAX_SHIFT_BITS),
		.DW(DW)
	) u_front (
		.start(start),
		.busy(busy),
		.prolog_bits(prolog_bits),
		.prolog_pattern(prolog_pattern),
		.shift_bits(shift_bits),
		.shift_data(shift_data),
		.capture(capture),
		.epilog_bits(epilog_bits),
		.epilog_pattern(epilog_pattern),
		.queue_full(queue_full),
		.push(push),
		.desc(push_desc),
		.data(push_data)
	);

	jsb_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({push_desc, push_data}),
		.pop(pop),
		.rdata({head_desc, head_data}),
		.full(queue_full),
		.empty(queue_empty)
	);

	jsb_back #(
		.DW(DW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.queue_empty(queue_empty),
		.head_desc(head_desc),
		.head_data(head_data),
		.pop(pop),
		.strobe(strobe),
		.cmd_byte(cmd_byte),
		.is_last(is_last),
		.reply_count(reply_count)
	);

endmodule
`default_nettype wire

>>> hdl/jsb_front.sv
// Front end: takes a scan request and classifies it into a command descriptor.
`default_nettype none
module jsb_front #(
	parameter int MAX_SHIFT_BITS = 64,
	parameter int DW             = 64
) (
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [3:0]      prolog_bits,
	input  wire logic [13:0]     prolog_pattern,
	input  wire logic [6:0]      shift_bits,
	input  wire logic [63:0]     shift_data,
	input  wire logic            capture,
	input  wire logic [2:0]      epilog_bits,
	input  wire logic [6:0]      epilog_pattern,
	input  wire logic            queue_full,
	output logic                 push,
	output jsb_pkg::jsb_desc_t   desc,
	output logic [DW-1:0]        data
);
	import jsb_pkg::*;

	logic [3:0] pbits_c;
	logic [6:0] sbits_c;
	logic [6:0] body_c;
	logic       fbit_en_c;
	logic       nrest_nz_c;
	logic       empty_c;

	assign busy = queue_full;

	always_comb begin
		pbits_c = (prolog_bits > 4'(PROLOG_MAX)) ? 4'(PROLOG_MAX) : prolog_bits;
		sbits_c = (shift_bits > 7'(MAX_SHIFT_BITS)) ? 7'(MAX_SHIFT_BITS) : shift_bits;
		fbit_en_c = (sbits_c != 7'd0) && (epilog_bits != 3'd0);
		// The final data bit is split off when an epilog follows the shift.
		body_c = fbit_en_c ? (sbits_c - 7'd1) : sbits_c;
		nrest_nz_c = (body_c[2:0] != 3'd0);
		empty_c = (pbits_c == 4'd0) && (sbits_c == 7'd0) && (epilog_bits == 3'd0);

		desc.pbits   = pbits_c;
		desc.ppat    = prolog_pattern;
		desc.nbytes  = body_c[6:3];
		desc.nrest   = body_c[2:0];
		desc.fbit_en = fbit_en_c;
		desc.fbit    = shift_data[body_c[5:0]];
		desc.rd      = capture;
		desc.ebits   = epilog_bits;
		desc.epat    = epilog_pattern;
		desc.reply   = capture ? (body_c[6:3] + 4'(nrest_nz_c) + 4'(fbit_en_c)) : 4'd0;
	end

	assign data = shift_data[DW-1:0];
	assign push = start && !queue_full && !empty_c;

endmodule
`default_nettype wire

>>> hdl/jsb_fifo.sv
// Short flip-flop queue between the front end and the byte sequencer.
`default_nettype none
module jsb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  full,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("transaction pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue occupancy out of range");

endmodule
`default_nettype wire

>>> hdl/jsb_back.sv
// Back end: walks one command descriptor and emits its bytes, one per cycle.
`default_nettype none
module jsb_back #(
	parameter int DW = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                queue_empty,
	input  wire jsb_pkg::jsb_desc_t  head_desc,
	input  wire logic [DW-1:0]       head_data,
	output logic                     pop,
	output logic                     strobe,
	output logic [7:0]               cmd_byte,
	output logic                     is_last,
	output logic [3:0]               reply_count
);
	import jsb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P_OP, ST_P_LEN, ST_P_PAT,
		ST_B_OP, ST_B_LEN, ST_B_ZERO, ST_B_DATA,
		ST_R_OP, ST_R_LEN, ST_R_DATA,
		ST_F_OP, ST_F_LEN, ST_F_DATA,
		ST_E_OP, ST_E_LEN, ST_E_PAT
	} state_t;

	function automatic state_t after_final(jsb_desc_t d);
		return (d.ebits != 3'd0) ? ST_E_OP : ST_IDLE;
	endfunction

	function automatic state_t after_rest(jsb_desc_t d);
		return d.fbit_en ? ST_F_OP : after_final(d);
	endfunction

	function automatic state_t after_bytes(jsb_desc_t d);
		return (d.nrest != 3'd0) ? ST_R_OP : after_rest(d);
	endfunction

	function automatic state_t after_prolog(jsb_desc_t d);
		return (d.nbytes != 4'd0) ? ST_B_OP : after_bytes(d);
	endfunction

	function automatic state_t first_phase(jsb_desc_t d);
		return (d.pbits != 4'd0) ? ST_P_OP : after_prolog(d);
	endfunction

	state_t        state_q;
	state_t        nxt_c;
	jsb_desc_t     desc_q;
	logic [DW-1:0] data_q;
	logic [3:0]    cnt_q;
	logic          chunk_q;
	logic [7:0]    byte_c;

	assign pop = (state_q == ST_IDLE) && !queue_empty;

	always_comb begin
		nxt_c  = state_q;
		byte_c = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				nxt_c = ST_IDLE;
			end
			ST_P_OP: begin
				byte_c = OP_TMS_WRITE;
				nxt_c  = ST_P_LEN;
			end
			ST_P_LEN: begin
				if (chunk_q) begin
					byte_c = 8'(desc_q.pbits - 4'(CHUNK_BITS + 1));
				end else if (desc_q.pbits <= 4'(CHUNK_BITS)) begin
					byte_c = 8'(desc_q.pbits - 4'd1);
				end else begin
					byte_c = 8'(CHUNK_BITS - 1);
				end
				nxt_c = ST_P_PAT;
			end
			ST_P_PAT: begin
				byte_c = chunk_q ? {1'b0, desc_q.ppat[13:7]} : {1'b0, desc_q.ppat[6:0]};
				// A prolog longer than one chunk goes out as a second TMS command.
				if (!chunk_q && (desc_q.pbits > 4'(CHUNK_BITS))) begin
					nxt_c = ST_P_OP;
				end else begin
					nxt_c = after_prolog(desc_q);
				end
			end
			ST_B_OP: begin
				byte_c = desc_q.rd ? OP_BYTES_RW : OP_BYTES_W;
				nxt_c  = ST_B_LEN;
			end
			ST_B_LEN: begin
				byte_c = 8'(desc_q.nbytes - 4'd1);
				nxt_c  = ST_B_ZERO;
			end
			ST_B_ZERO: begin
				byte_c = 8'h00;
				nxt_c  = ST_B_DATA;
			end
			ST_B_DATA: begin
				byte_c = data_q[7:0];
				nxt_c  = (cnt_q == (desc_q.nbytes - 4'd1)) ? after_bytes(desc_q) : ST_B_DATA;
			end
			ST_R_OP: begin
				byte_c = desc_q.rd ? OP_BITS_RW : OP_BITS_W;
				nxt_c  = ST_R_LEN;
			end
			ST_R_LEN: begin
				byte_c = 8'(desc_q.nrest - 3'd1);
				nxt_c  = ST_R_DATA;
			end
			ST_R_DATA: begin
				byte_c = data_q[7:0];
				nxt_c  = after_rest(desc_q);
			end
			ST_F_OP: begin
				byte_c = desc_q.rd ? OP_TMS_READ : OP_TMS_WRITE;
				nxt_c  = ST_F_LEN;
			end
			ST_F_LEN: begin
				byte_c = 8'h00;
				nxt_c  = ST_F_DATA;
			end
			ST_F_DATA: begin
				byte_c = FINAL_BIT_BASE | {desc_q.fbit, 7'd0};
				nxt_c  = after_final(desc_q);
			end
			ST_E_OP: begin
				byte_c = OP_TMS_WRITE;
				nxt_c  = ST_E_LEN;
			end
			ST_E_LEN: begin
				byte_c = 8'(desc_q.ebits - 3'd1);
				nxt_c  = ST_E_PAT;
			end
			ST_E_PAT: begin
				byte_c = {1'b0, desc_q.epat};
				nxt_c  = ST_IDLE;
			end
			default: begin
				nxt_c = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			desc_q      <= '0;
			data_q      <= '0;
			cnt_q       <= '0;
			chunk_q     <= 1'b0;
			strobe      <= 1'b0;
			cmd_byte    <= '0;
			is_last     <= 1'b0;
			reply_count <= '0;
		end else begin
			strobe      <= (state_q != ST_IDLE);
			cmd_byte    <= byte_c;
			is_last     <= (state_q != ST_IDLE) && (nxt_c == ST_IDLE);
			reply_count <= desc_q.reply;
			if (pop) begin
				state_q <= first_phase(head_desc);
				desc_q  <= head_desc;
				data_q  <= head_data;
				cnt_q   <= '0;
				chunk_q <= 1'b0;
			end else begin
				state_q <= nxt_c;
				if (state_q == ST_P_PAT) begin
					chunk_q <= 1'b1;
				end
				if (state_q == ST_B_DATA) begin
					data_q <= data_q >> 8;
					cnt_q  <= cnt_q + 4'd1;
				end
			end
		end
	end

	a_busy_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> strobe) else $error("sequencer step without a byte");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_last) |-> (state_q == ST_IDLE))
		else $error("last byte marked while the request continues");
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !is_last) |-> (state_q != ST_IDLE))
		else $error("request ended without a last byte");

endmodule
`default_nettype wire

>>> tb/tb_jtag_scan_command_builder.sv
// Self-checking testbench for the JTAG scan command builder: directed table, then random requests.
`timescale 1ns / 100ps
module tb_jtag_scan_command_builder;
	import jsb_pkg::*;

	typedef struct packed {
		logic [3:0]  pbits;
		logic [13:0] ppat;
		logic [6:0]  sbits;
		logic [63:0] data;
		logic        capture;
		logic [2:0]  ebits;
		logic [6:0]  epat;
	} scan_req_t;

	typedef struct packed {
		logic [7:0] cmd;
		logic       last;
		logic [3:0] reply;
	} cmd_expect_t;

	// A fixed_len of -1 leaves the row to the predictor.
	typedef struct {
		scan_req_t   req;
		int          fixed_len;
		logic [23:0] fixed_bytes;
	} directed_row_t;

	localparam int RANDOM_REQUESTS = 300;
	localparam int DRAIN_CYCLES    = 40;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  prolog_bits;
	logic [13:0] prolog_pattern;
	logic [6:0]  shift_bits;
	logic [63:0] shift_data;
	logic        capture;
	logic [2:0]  epilog_bits;
	logic [6:0]  epilog_pattern;
	logic        strobe;
	logic [7:0]  cmd_byte;
	logic        is_last;
	logic [3:0]  reply_count;

	cmd_expect_t   pending_bytes [$];
	directed_row_t directed_table [$];
	int            error_count = 0;
	int            bytes_checked = 0;
	int            requests_sent = 0;

	jtag_scan_command_builder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.prolog_bits    (prolog_bits),
		.prolog_pattern (prolog_pattern),
		.shift_bits     (shift_bits),
		.shift_data     (shift_data),
		.capture        (capture),
		.epilog_bits    (epilog_bits),
		.epilog_pattern (epilog_pattern),
		.strobe         (strobe),
		.cmd_byte       (cmd_byte),
		.is_last        (is_last),
		.reply_count    (reply_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Timed out with %0d command bytes still pending.", pending_bytes.size());
		$display("FAIL");
		$finish;
	end

	function automatic scan_req_t make_req(input int pb, input int pp, input int sb,
			input logic [63:0] data, input int cap, input int eb, input int ep);
		scan_req_t r;
		r.pbits   = 4'(pb);
		r.ppat    = 14'(pp);
		r.sbits   = 7'(sb);
		r.data    = data;
		r.capture = 1'(cap);
		r.ebits   = 3'(eb);
		r.epat    = 7'(ep);
		return r;
	endfunction

	function automatic void add_row(input scan_req_t r, input int fixed_len,
			input logic [23:0] fixed_bytes);
		directed_row_t row;
		row.req         = r;
		row.fixed_len   = fixed_len;
		row.fixed_bytes = fixed_bytes;
		directed_table.push_back(row);
	endfunction

	// Expands one request into the command bytes the serial engine should see.
	function automatic void predict_command_stream(input scan_req_t r);
		logic [7:0]  stream [$];
		cmd_expect_t e;
		logic [63:0] d;
		int          pb;
		int          sb;
		int          body;
		int          nbytes;
		int          nrest;
		int          reply;

		pb    = (r.pbits > PROLOG_MAX) ? PROLOG_MAX : int'(r.pbits);
		sb    = (r.sbits > MAX_SHIFT_BITS_DEF) ? MAX_SHIFT_BITS_DEF : int'(r.sbits);
		reply = 0;
		d     = r.data;
		if (pb != 0) begin
			stream.push_back(OP_TMS_WRITE);
			if (pb <= CHUNK_BITS) begin
				stream.push_back(8'(pb - 1));
				stream.push_back({1'b0, r.ppat[6:0]});
			end else begin
				stream.push_back(8'(CHUNK_BITS - 1));
				stream.push_back({1'b0, r.ppat[6:0]});
				stream.push_back(OP_TMS_WRITE);
				stream.push_back(8'(pb - CHUNK_BITS - 1));
				stream.push_back({1'b0, r.ppat[13:7]});
			end
		end
		if (sb != 0) begin
			// With an epilog the last data bit leaves on the TMS command instead.
			body   = (r.ebits != 0) ? sb - 1 : sb;
			nbytes = body / 8;
			nrest  = body % 8;
			if (r.capture)
				reply += nbytes + ((nrest > 0) ? 1 : 0);
			if (nbytes > 0) begin
				stream.push_back(r.capture ? OP_BYTES_RW : OP_BYTES_W);
				stream.push_back(8'(nbytes - 1));
				stream.push_back(8'h00);
				for (int i = 0; i < nbytes; i++) begin
					stream.push_back(d[7:0]);
					d = d >> 8;
				end
			end
			if (nrest > 0) begin
				stream.push_back(r.capture ? OP_BITS_RW : OP_BITS_W);
				stream.push_back(8'(nrest - 1));
				stream.push_back(d[7:0]);
			end
			if (r.ebits != 0) begin
				d = d >> nrest;
				stream.push_back(r.capture ? OP_TMS_READ : OP_TMS_WRITE);
				stream.push_back(8'h00);
				stream.push_back({d[0], FINAL_BIT_BASE[6:0]});
				if (r.capture)
					reply += 1;
			end
		end
		if (r.ebits != 0) begin
			stream.push_back(OP_TMS_WRITE);
			stream.push_back(8'(r.ebits - 1));
			stream.push_back({1'b0, r.epat});
		end
		foreach (stream[k]) begin
			e.cmd   = stream[k];
			e.last  = (k == stream.size() - 1);
			e.reply = 4'(reply);
			pending_bytes.push_back(e);
		end
	endfunction

	function automatic scan_req_t random_request();
		scan_req_t r;
		int        mode;

		r = make_req($urandom_range(0, 15), $urandom_range(0, 16383), 0,
			{$urandom, $urandom}, $urandom_range(0, 1), $urandom_range(0, 7),
			$urandom_range(0, 127));
		mode = $urandom_range(0, 9);
		if (mode == 1)
			r.sbits = 7'($urandom_range(65, 127));
		else if (mode != 0)
			r.sbits = 7'($urandom_range(1, 64));
		// Now and then an empty request, patterns left random.
		if ($urandom_range(0, 19) == 0) begin
			r.pbits = '0;
			r.sbits = '0;
			r.ebits = '0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;

		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Returns at the rising edge where the transaction was taken.
	task automatic send_request(input scan_req_t r, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		prolog_bits    = r.pbits;
		prolog_pattern = r.ppat;
		shift_bits     = r.sbits;
		shift_data     = r.data;
		capture        = r.capture;
		epilog_bits    = r.ebits;
		epilog_pattern = r.epat;
		start          = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	always @(posedge clk) begin : byte_checker
		cmd_expect_t e;

		if (arst_n && strobe) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected command byte %02h, is_last %0b, reply_count %0d",
					$time, cmd_byte, is_last, reply_count);
				error_count++;
			end else begin
				e = pending_bytes.pop_front();
				bytes_checked++;
				if (cmd_byte !== e.cmd) begin
					$display("%0t: cmd_byte expected %02h, actual %02h", $time, e.cmd, cmd_byte);
					error_count++;
				end
				if (is_last !== e.last) begin
					$display("%0t: is_last expected %0b, actual %0b", $time, e.last, is_last);
					error_count++;
				end
				if (reply_count !== e.reply) begin
					$display("%0t: reply_count expected %0d, actual %0d",
						$time, e.reply, reply_count);
					error_count++;
				end
			end
		end
	end

	initial begin
		cmd_expect_t e;
		scan_req_t   r;
		int          burst_left;

		arst_n         = 1'b0;
		start          = 1'b0;
		prolog_bits    = '0;
		prolog_pattern = '0;
		shift_bits     = '0;
		shift_data     = '0;
		capture        = 1'b0;
		epilog_bits    = '0;
		epilog_pattern = '0;
		burst_left     = 0;

		add_row(make_req(0, 0, 0, 64'h0, 0, 0, 0), 0, 24'h0);
		add_row(make_req(1, 16'h3fff, 0, 64'h0, 0, 0, 0), 3, {OP_TMS_WRITE, 8'h00, 8'h7f});
		add_row(make_req(0, 0, 0, 64'h0, 1, 7, 8'h7f), 3, {OP_TMS_WRITE, 8'h06, 8'h7f});
		add_row(make_req(0, 0, 0, 64'h0, 0, 1, 0), 3, {OP_TMS_WRITE, 8'h00, 8'h00});
		add_row(make_req(0, 0, 1, 64'h0, 0, 0, 0), 3, {OP_BITS_W, 8'h00, 8'h00});
		add_row(make_req(7, 16'h2aaa, 0, 64'h0, 0, 0, 0), -1, 24'h0);
		add_row(make_req(8, 16'h3fff, 0, 64'h0, 0, 0, 0), -1, 24'h0);
		add_row(make_req(14, 16'h1555, 0, 64'h0, 0, 0, 0), -1, 24'h0);
		add_row(make_req(15, 16'h3fff, 0, 64'h0, 0, 0, 0), -1, 24'h0);
		add_row(make_req(0, 0, 1, 64'h1, 1, 1, 1), -1, 24'h0);
		add_row(make_req(0, 0, 8, {64{1'b1}}, 1, 0, 0), -1, 24'h0);
		add_row(make_req(0, 0, 64, {64{1'b1}}, 1, 0, 0), -1, 24'h0);
		add_row(make_req(14, 16'h3fff, 64, 64'h0123456789abcdef, 1, 7, 8'h55), -1, 24'h0);
		add_row(make_req(3, 16'h0005, 127, 64'hfedcba9876543210, 0, 3, 8'h05), -1, 24'h0);
		add_row(make_req(0, 0, 65, 64'h8000000000000001, 1, 0, 0), -1, 24'h0);
		add_row(make_req(0, 0, 9, 64'h100, 0, 1, 1), -1, 24'h0);
		add_row(make_req(0, 0, 7, 64'hffff_0000_0000_f0ff, 0, 0, 0), -1, 24'h0);
		add_row(make_req(2, 16'h0003, 15, {64{1'b1}}, 1, 2, 8'h02), -1, 24'h0);
		add_row(make_req(3, 16'h0007, 0, {64{1'b1}}, 1, 0, 0), -1, 24'h0);
		add_row(make_req(14, 0, 64, 64'h0, 0, 7, 0), -1, 24'h0);
		add_row(make_req(5, 16'h0015, 16, 64'haaaa_aaaa_aaaa_aaaa, 1, 5, 8'h15), -1, 24'h0);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_table[i]) begin
			send_request(directed_table[i].req, (i % 4 == 3) ? 2 : 0);
			if (directed_table[i].fixed_len < 0) begin
				predict_command_stream(directed_table[i].req);
			end else begin
				for (int k = 0; k < directed_table[i].fixed_len; k++) begin
					e.cmd   = directed_table[i].fixed_bytes[23 - 8 * k -: 8];
					e.last  = (k == directed_table[i].fixed_len - 1);
					e.reply = 4'd0;
					pending_bytes.push_back(e);
				end
			end
		end

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// Every so often let the builder drain completely before going on.
			if (n % 75 == 40) begin
				@(negedge clk);
				start = 1'b0;
				wait (pending_bytes.size() == 0);
			end
			if (burst_left == 0 && $urandom_range(0, 29) == 0)
				burst_left = $urandom_range(10, 25);
			r = random_request();
			if (burst_left > 0) begin
				burst_left--;
				send_request(r, 0);
			end else begin
				send_request(r, pick_gap());
			end
			predict_command_stream(r);
		end

		@(negedge clk);
		start = 1'b0;
		wait (pending_bytes.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d scan requests (%0d from the directed table), checked %0d command bytes.",
			requests_sent, directed_table.size(), bytes_checked);
		$display("Errors found: %0d.", error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
